// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the pipeline modules.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/bpfj_pkg.sv =====
package bpfj_pkg;

    // Default CORDIC depth and a size for the arctangent table; atan_q28 below lists 29 entries
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int ATAN_ENTRIES      = 30;

    // Angle constants, Q4.28 radians
    localparam logic signed [34:0] ANG_PI      = 35'sd843314857;
    localparam logic signed [34:0] ANG_TWO_PI  = 35'sd1686629713;
    localparam logic signed [34:0] ANG_HALF_PI = 35'sd421657428;

    // CORDIC start value 1/K and unit, Q2.30
    localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;
    localparam logic signed [33:0] UNIT_Q30    = 34'sd1073741824;

    // Output saturation bounds, Q24.24
    localparam logic signed [49:0] SAT48_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] SAT48_MIN = -50'sd140737488355328;

    typedef struct packed {
        logic signed [31:0] g_self;
        logic signed [31:0] b_self;
        logic signed [31:0] g_mutual;
        logic signed [31:0] b_mutual;
        logic        [15:0] vm_near;
        logic signed [31:0] angle_near;
        logic        [15:0] vm_far;
        logic signed [31:0] angle_far;
        logic               in_service;
    } item_t;

    typedef struct packed {
        logic signed [47:0] p_flow;
        logic signed [47:0] q_flow;
        logic signed [47:0] dp_dangle_near;
        logic signed [47:0] dp_dvm_near;
        logic signed [47:0] dp_dangle_far;
        logic signed [47:0] dp_dvm_far;
        logic signed [47:0] dq_dangle_near;
        logic signed [47:0] dq_dvm_near;
        logic signed [47:0] dq_dangle_far;
        logic signed [47:0] dq_dvm_far;
    } result_t;

    // Reduced angle handed to the CORDIC
    typedef struct packed {
        logic signed [31:0] z;
        logic               flip;
    } angle_t;

    // atan(2^-i) in Q4.28
    function automatic logic signed [31:0] atan_q28(input int idx);
        logic signed [31:0] r;
        case (idx)
            0:  r = 32'sd210828714;
            1:  r = 32'sd124459457;
            2:  r = 32'sd65760959;
            3:  r = 32'sd33381290;
            4:  r = 32'sd16755422;
            5:  r = 32'sd8385879;
            6:  r = 32'sd4193963;
            7:  r = 32'sd2097109;
            8:  r = 32'sd1048571;
            9:  r = 32'sd524287;
            10: r = 32'sd262144;
            11: r = 32'sd131072;
            12: r = 32'sd65536;
            13: r = 32'sd32768;
            14: r = 32'sd16384;
            15: r = 32'sd8192;
            16: r = 32'sd4096;
            17: r = 32'sd2048;
            18: r = 32'sd1024;
            19: r = 32'sd512;
            20: r = 32'sd256;
            21: r = 32'sd128;
            22: r = 32'sd64;
            23: r = 32'sd32;
            24: r = 32'sd16;
            25: r = 32'sd8;
            26: r = 32'sd4;
            27: r = 32'sd2;
            28: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // Signed value from sign flag and magnitude
    function automatic logic signed [49:0] apply_sign(input logic neg, input logic [47:0] mag);
        logic signed [49:0] v;
        v = $signed({2'b00, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v > SAT48_MAX)
        begin
            r = SAT48_MAX[47:0];
        end
        else if (v < SAT48_MIN)
        begin
            r = SAT48_MIN[47:0];
        end
        else
        begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/branch_power_flow_jacobian.sv =====
// Channel   Ports                      Handshake
// --------  -------------------------  ------------------------------------
// input     start, busy, request       taken when start && !busy
// result    done, result               done marks one cycle, always taken
//
// One item is taken every cycle; busy is always low.
// Between accept and done an item passes two angle stages, one per
// CORDIC rotation plus one for sign fix and clamp, and six for products,
// rounding and sums.
// Reset clears only the valid bits; data registers are not reset.
// Nothing stalls: the pipeline advances on every clock edge.
`include "assert_macros.svh"

module branch_power_flow_jacobian #(
    parameter int CORDIC_STAGES = bpfj_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bpfj_pkg::item_t    request,
    output logic               done,
    output bpfj_pkg::result_t  result
);

    localparam int DELAY   = CORDIC_STAGES + 3;
    localparam int LATENCY = CORDIC_STAGES + 9;

    logic               accept;
    logic               ang_valid;
    bpfj_pkg::angle_t   ang;
    logic               trig_valid;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    bpfj_pkg::item_t    dly_reg [0:DELAY-1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Item fields ride alongside the angle path
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= request;
        for (int k = 1; k < DELAY; k++)
        begin
            dly_reg[k] <= dly_reg[k-1];
        end
    end

    bpfj_angle u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .angle_near (request.angle_near),
        .angle_far  (request.angle_far),
        .out_valid  (ang_valid),
        .out_angle  (ang)
    );

    bpfj_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .in_angle  (ang),
        .out_valid (trig_valid),
        .cos_out   (cos_v),
        .sin_out   (sin_v)
    );

    bpfj_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .cos_in    (cos_v),
        .sin_in    (sin_v),
        .item      (dly_reg[DELAY-1]),
        .out_valid (done),
        .result    (result)
    );

    `ASSERT_IMPL(a_latency_fwd, accept, ##LATENCY done)
    `ASSERT_IMPL(a_latency_back, done, $past(accept, LATENCY))

endmodule

// ===== sv/bpfj_angle.sv =====
`include "assert_macros.svh"

// Angle difference, reduction to [-pi, pi], fold to [-pi/2, pi/2]
module bpfj_angle (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [31:0]  angle_near,
    input  logic signed [31:0]  angle_far,
    output logic                out_valid,
    output bpfj_pkg::angle_t    out_angle
);

    logic signed [34:0] d;
    logic signed [34:0] dr;
    logic signed [31:0] dr_reg;
    logic               v1_reg;
    bpfj_pkg::angle_t   fold_next;
    bpfj_pkg::angle_t   fold_reg;
    logic               v2_reg;

    // Stage 1: difference and wrap by up to three turns
    always_comb
    begin
        d  = 35'(angle_near) - 35'(angle_far);
        dr = d;
        if (d > bpfj_pkg::ANG_PI)
        begin
            if (d - bpfj_pkg::ANG_TWO_PI <= bpfj_pkg::ANG_PI)
            begin
                dr = d - bpfj_pkg::ANG_TWO_PI;
            end
            else if (d - 35'sd2 * bpfj_pkg::ANG_TWO_PI <= bpfj_pkg::ANG_PI)
            begin
                dr = d - 35'sd2 * bpfj_pkg::ANG_TWO_PI;
            end
            else
            begin
                dr = d - 35'sd3 * bpfj_pkg::ANG_TWO_PI;
            end
        end
        else if (d < -bpfj_pkg::ANG_PI)
        begin
            if (d + bpfj_pkg::ANG_TWO_PI >= -bpfj_pkg::ANG_PI)
            begin
                dr = d + bpfj_pkg::ANG_TWO_PI;
            end
            else if (d + 35'sd2 * bpfj_pkg::ANG_TWO_PI >= -bpfj_pkg::ANG_PI)
            begin
                dr = d + 35'sd2 * bpfj_pkg::ANG_TWO_PI;
            end
            else
            begin
                dr = d + 35'sd3 * bpfj_pkg::ANG_TWO_PI;
            end
        end
    end

    // Stage 2: move outer half-plane by pi, remember to negate
    always_comb
    begin
        fold_next.z    = dr_reg;
        fold_next.flip = 1'b0;
        if (35'(dr_reg) > bpfj_pkg::ANG_HALF_PI)
        begin
            fold_next.z    = 32'(35'(dr_reg) - bpfj_pkg::ANG_PI);
            fold_next.flip = 1'b1;
        end
        else if (35'(dr_reg) < -bpfj_pkg::ANG_HALF_PI)
        begin
            fold_next.z    = 32'(35'(dr_reg) + bpfj_pkg::ANG_PI);
            fold_next.flip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg   <= dr[31:0];
        fold_reg <= fold_next;
    end

    assign out_valid = v2_reg;
    assign out_angle = fold_reg;

    `ASSERT_IMPL(a_fold_range, out_valid,
        (35'(out_angle.z) <= bpfj_pkg::ANG_HALF_PI) && (35'(out_angle.z) >= -bpfj_pkg::ANG_HALF_PI))

endmodule

// ===== sv/bpfj_cordic.sv =====
`include "assert_macros.svh"

// Rotation-mode CORDIC, one stage per register, then sign fix and clamp
module bpfj_cordic #(
    parameter int CORDIC_STAGES = bpfj_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bpfj_pkg::angle_t    in_angle,
    output logic                out_valid,
    output logic signed [31:0]  cos_out,
    output logic signed [31:0]  sin_out
);

    logic signed [33:0] x_reg [0:CORDIC_STAGES-1];
    logic signed [33:0] y_reg [0:CORDIC_STAGES-1];
    logic signed [31:0] z_reg [0:CORDIC_STAGES-1];
    logic               f_reg [0:CORDIC_STAGES-1];
    logic               v_reg [0:CORDIC_STAGES-1];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            localparam logic signed [31:0] ATAN_I = bpfj_pkg::atan_q28(i);
            logic signed [33:0] xi;
            logic signed [33:0] yi;
            logic signed [31:0] zi;
            logic               fi;
            logic               vi;

            if (i == 0)
            begin : g_first
                assign xi = bpfj_pkg::CORDIC_KINV;
                assign yi = 34'sd0;
                assign zi = in_angle.z;
                assign fi = in_angle.flip;
                assign vi = in_valid;
            end
            else
            begin : g_rest
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign fi = f_reg[i-1];
                assign vi = v_reg[i-1];
            end

            // Micro-rotation toward z = 0
            always_ff @(posedge clk)
            begin
                if (zi >= 32'sd0)
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - ATAN_I;
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + ATAN_I;
                end
                f_reg[i] <= fi;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else
                begin
                    v_reg[i] <= vi;
                end
            end
        end
    endgenerate

    logic signed [33:0] xf;
    logic signed [33:0] yf;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic               vout_reg;

    // Undo the half-plane fold, clamp to the unit
    always_comb
    begin
        xf = f_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1] : x_reg[CORDIC_STAGES-1];
        yf = f_reg[CORDIC_STAGES-1] ? -y_reg[CORDIC_STAGES-1] : y_reg[CORDIC_STAGES-1];
        if (xf > bpfj_pkg::UNIT_Q30)
        begin
            cos_next = bpfj_pkg::UNIT_Q30[31:0];
        end
        else if (xf < -bpfj_pkg::UNIT_Q30)
        begin
            cos_next = 32'(-bpfj_pkg::UNIT_Q30);
        end
        else
        begin
            cos_next = xf[31:0];
        end
        if (yf > bpfj_pkg::UNIT_Q30)
        begin
            sin_next = bpfj_pkg::UNIT_Q30[31:0];
        end
        else if (yf < -bpfj_pkg::UNIT_Q30)
        begin
            sin_next = 32'(-bpfj_pkg::UNIT_Q30);
        end
        else
        begin
            sin_next = yf[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else
        begin
            vout_reg <= v_reg[CORDIC_STAGES-1];
        end
    end

    assign out_valid = vout_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

    `ASSERT_NEXT(a_cordic_flow, v_reg[CORDIC_STAGES-1], out_valid)

endmodule

// ===== sv/bpfj_terms.sv =====
`include "assert_macros.svh"

// Products, rounding to Q24.24, sums and saturation: six register stages
module bpfj_terms (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [31:0]  cos_in,
    input  logic signed [31:0]  sin_in,
    input  bpfj_pkg::item_t     item,
    output logic                out_valid,
    output bpfj_pkg::result_t   result
);

    logic [5:0] v_reg;

    // ---- stage 1: trig products, voltage products, self-term magnitudes
    logic signed [63:0] s1_gc_reg, s1_bs_reg, s1_gs_reg, s1_bc_reg;
    logic [31:0]        s1_vv_reg, s1_vn2_reg;
    logic [31:0]        s1_ag_reg, s1_ab_reg;
    logic               s1_ng_reg, s1_nb_reg;
    logic [15:0]        s1_vn_reg, s1_vf_reg;
    logic               s1_svc_reg;

    always_ff @(posedge clk)
    begin
        s1_gc_reg  <= 64'(item.g_mutual) * 64'(cos_in);
        s1_bs_reg  <= 64'(item.b_mutual) * 64'(sin_in);
        s1_gs_reg  <= 64'(item.g_mutual) * 64'(sin_in);
        s1_bc_reg  <= 64'(item.b_mutual) * 64'(cos_in);
        s1_vv_reg  <= 32'(item.vm_near) * 32'(item.vm_far);
        s1_vn2_reg <= 32'(item.vm_near) * 32'(item.vm_near);
        s1_ag_reg  <= item.g_self[31] ? 32'(-item.g_self) : 32'(item.g_self);
        s1_ab_reg  <= item.b_self[31] ? 32'(-item.b_self) : 32'(item.b_self);
        s1_ng_reg  <= item.g_self[31];
        s1_nb_reg  <= item.b_self[31];
        s1_vn_reg  <= item.vm_near;
        s1_vf_reg  <= item.vm_far;
        s1_svc_reg <= item.in_service;
    end

    // ---- stage 2: combined mutual terms, self products
    logic signed [63:0] s2_c1_reg, s2_c2_reg;
    logic [63:0]        s2_g2_reg, s2_b2_reg;
    logic [47:0]        s2_gn_reg, s2_bn_reg;
    logic               s2_ng_reg, s2_nb_reg;
    logic [31:0]        s2_vv_reg;
    logic [15:0]        s2_vn_reg, s2_vf_reg;
    logic               s2_svc_reg;

    always_ff @(posedge clk)
    begin
        s2_c1_reg  <= s1_gc_reg + s1_bs_reg;
        s2_c2_reg  <= s1_gs_reg - s1_bc_reg;
        s2_g2_reg  <= 64'(s1_ag_reg) * 64'(s1_vn2_reg);
        s2_b2_reg  <= 64'(s1_ab_reg) * 64'(s1_vn2_reg);
        s2_gn_reg  <= 48'(s1_ag_reg) * 48'(s1_vn_reg);
        s2_bn_reg  <= 48'(s1_ab_reg) * 48'(s1_vn_reg);
        s2_ng_reg  <= s1_ng_reg;
        s2_nb_reg  <= s1_nb_reg;
        s2_vv_reg  <= s1_vv_reg;
        s2_vn_reg  <= s1_vn_reg;
        s2_vf_reg  <= s1_vf_reg;
        s2_svc_reg <= s1_svc_reg;
    end

    // ---- stage 3: magnitudes of mutual terms, round self terms
    // |c1|, |c2| never exceed 2^62, so 63 bits hold them
    logic [63:0]  s3_g2r, s3_b2r;
    logic [47:0]  s3_gnr, s3_bnr;
    logic [62:0]  s3_m1_reg, s3_m2_reg;
    logic         s3_n1_reg, s3_n2_reg;
    logic [39:0]  s3_g2_reg, s3_b2_reg;
    logic [38:0]  s3_gn_reg, s3_bn_reg;
    logic         s3_ng_reg, s3_nb_reg;
    logic [31:0]  s3_vv_reg;
    logic [15:0]  s3_vn_reg, s3_vf_reg;
    logic         s3_svc_reg;

    always_comb
    begin
        s3_g2r = s2_g2_reg + (64'd1 << 23);
        s3_b2r = s2_b2_reg + (64'd1 << 23);
        s3_gnr = s2_gn_reg + (48'd1 << 8);
        s3_bnr = s2_bn_reg + (48'd1 << 8);
    end

    always_ff @(posedge clk)
    begin
        s3_m1_reg  <= s2_c1_reg[63] ? 63'(-s2_c1_reg) : s2_c1_reg[62:0];
        s3_m2_reg  <= s2_c2_reg[63] ? 63'(-s2_c2_reg) : s2_c2_reg[62:0];
        s3_n1_reg  <= s2_c1_reg[63];
        s3_n2_reg  <= s2_c2_reg[63];
        s3_g2_reg  <= s3_g2r[63:24];
        s3_b2_reg  <= s3_b2r[63:24];
        s3_gn_reg  <= s3_gnr[47:9];
        s3_bn_reg  <= s3_bnr[47:9];
        s3_ng_reg  <= s2_ng_reg;
        s3_nb_reg  <= s2_nb_reg;
        s3_vv_reg  <= s2_vv_reg;
        s3_vn_reg  <= s2_vn_reg;
        s3_vf_reg  <= s2_vf_reg;
        s3_svc_reg <= s2_svc_reg;
    end

    // ---- stage 4: partial products, low and high halves of |c|
    logic [63:0] s4_l1vv_reg, s4_l2vv_reg;
    logic [62:0] s4_h1vv_reg, s4_h2vv_reg;
    logic [47:0] s4_l1vf_reg, s4_l2vf_reg, s4_l1vn_reg, s4_l2vn_reg;
    logic [46:0] s4_h1vf_reg, s4_h2vf_reg, s4_h1vn_reg, s4_h2vn_reg;
    logic        s4_n1_reg, s4_n2_reg;
    logic [39:0] s4_g2_reg, s4_b2_reg;
    logic [38:0] s4_gn_reg, s4_bn_reg;
    logic        s4_ng_reg, s4_nb_reg;
    logic        s4_svc_reg;

    always_ff @(posedge clk)
    begin
        s4_l1vv_reg <= 64'(s3_m1_reg[31:0]) * 64'(s3_vv_reg);
        s4_h1vv_reg <= 63'(s3_m1_reg[62:32]) * 63'(s3_vv_reg);
        s4_l2vv_reg <= 64'(s3_m2_reg[31:0]) * 64'(s3_vv_reg);
        s4_h2vv_reg <= 63'(s3_m2_reg[62:32]) * 63'(s3_vv_reg);
        s4_l1vf_reg <= 48'(s3_m1_reg[31:0]) * 48'(s3_vf_reg);
        s4_h1vf_reg <= 47'(s3_m1_reg[62:32]) * 47'(s3_vf_reg);
        s4_l2vf_reg <= 48'(s3_m2_reg[31:0]) * 48'(s3_vf_reg);
        s4_h2vf_reg <= 47'(s3_m2_reg[62:32]) * 47'(s3_vf_reg);
        s4_l1vn_reg <= 48'(s3_m1_reg[31:0]) * 48'(s3_vn_reg);
        s4_h1vn_reg <= 47'(s3_m1_reg[62:32]) * 47'(s3_vn_reg);
        s4_l2vn_reg <= 48'(s3_m2_reg[31:0]) * 48'(s3_vn_reg);
        s4_h2vn_reg <= 47'(s3_m2_reg[62:32]) * 47'(s3_vn_reg);
        s4_n1_reg   <= s3_n1_reg;
        s4_n2_reg   <= s3_n2_reg;
        s4_g2_reg   <= s3_g2_reg;
        s4_b2_reg   <= s3_b2_reg;
        s4_gn_reg   <= s3_gn_reg;
        s4_bn_reg   <= s3_bn_reg;
        s4_ng_reg   <= s3_ng_reg;
        s4_nb_reg   <= s3_nb_reg;
        s4_svc_reg  <= s3_svc_reg;
    end

    // ---- stage 5: join halves, round half away from zero on magnitude
    logic [95:0] s5_t1, s5_t2;
    logic [79:0] s5_a1f, s5_a2f, s5_a1n, s5_a2n;
    logic [40:0] s5_t1_reg, s5_t2_reg;
    logic [39:0] s5_a1f_reg, s5_a2f_reg, s5_a1n_reg, s5_a2n_reg;
    logic        s5_n1_reg, s5_n2_reg;
    logic [39:0] s5_g2_reg, s5_b2_reg;
    logic [38:0] s5_gn_reg, s5_bn_reg;
    logic        s5_ng_reg, s5_nb_reg;
    logic        s5_svc_reg;

    always_comb
    begin
        s5_t1  = {1'b0, s4_h1vv_reg, 32'd0} + 96'(s4_l1vv_reg) + (96'd1 << 53);
        s5_t2  = {1'b0, s4_h2vv_reg, 32'd0} + 96'(s4_l2vv_reg) + (96'd1 << 53);
        s5_a1f = {1'b0, s4_h1vf_reg, 32'd0} + 80'(s4_l1vf_reg) + (80'd1 << 39);
        s5_a2f = {1'b0, s4_h2vf_reg, 32'd0} + 80'(s4_l2vf_reg) + (80'd1 << 39);
        s5_a1n = {1'b0, s4_h1vn_reg, 32'd0} + 80'(s4_l1vn_reg) + (80'd1 << 39);
        s5_a2n = {1'b0, s4_h2vn_reg, 32'd0} + 80'(s4_l2vn_reg) + (80'd1 << 39);
    end

    always_ff @(posedge clk)
    begin
        s5_t1_reg  <= s5_t1[94:54];
        s5_t2_reg  <= s5_t2[94:54];
        s5_a1f_reg <= s5_a1f[79:40];
        s5_a2f_reg <= s5_a2f[79:40];
        s5_a1n_reg <= s5_a1n[79:40];
        s5_a2n_reg <= s5_a2n[79:40];
        s5_n1_reg  <= s4_n1_reg;
        s5_n2_reg  <= s4_n2_reg;
        s5_g2_reg  <= s4_g2_reg;
        s5_b2_reg  <= s4_b2_reg;
        s5_gn_reg  <= s4_gn_reg;
        s5_bn_reg  <= s4_bn_reg;
        s5_ng_reg  <= s4_ng_reg;
        s5_nb_reg  <= s4_nb_reg;
        s5_svc_reg <= s4_svc_reg;
    end

    // ---- stage 6: signs, sums, saturation, out-of-service zeroing
    logic signed [49:0] t1, t2, a1f, a2f, a1n, a2n, g2, b2, gn, bn;
    bpfj_pkg::result_t  res_next;
    bpfj_pkg::result_t  res_reg;

    always_comb
    begin
        t1  = bpfj_pkg::apply_sign(s5_n1_reg, 48'(s5_t1_reg));
        t2  = bpfj_pkg::apply_sign(s5_n2_reg, 48'(s5_t2_reg));
        a1f = bpfj_pkg::apply_sign(s5_n1_reg, 48'(s5_a1f_reg));
        a2f = bpfj_pkg::apply_sign(s5_n2_reg, 48'(s5_a2f_reg));
        a1n = bpfj_pkg::apply_sign(s5_n1_reg, 48'(s5_a1n_reg));
        a2n = bpfj_pkg::apply_sign(s5_n2_reg, 48'(s5_a2n_reg));
        g2  = bpfj_pkg::apply_sign(s5_ng_reg, 48'(s5_g2_reg));
        b2  = bpfj_pkg::apply_sign(s5_nb_reg, 48'(s5_b2_reg));
        gn  = bpfj_pkg::apply_sign(s5_ng_reg, 48'(s5_gn_reg));
        bn  = bpfj_pkg::apply_sign(s5_nb_reg, 48'(s5_bn_reg));
        res_next.p_flow         = bpfj_pkg::sat48(g2 + t1);
        res_next.q_flow         = bpfj_pkg::sat48(t2 - b2);
        res_next.dp_dangle_near = bpfj_pkg::sat48(-t2);
        res_next.dp_dvm_near    = bpfj_pkg::sat48(gn + a1f);
        res_next.dp_dangle_far  = bpfj_pkg::sat48(t2);
        res_next.dp_dvm_far     = bpfj_pkg::sat48(a1n);
        res_next.dq_dangle_near = bpfj_pkg::sat48(t1);
        res_next.dq_dvm_near    = bpfj_pkg::sat48(a2f - bn);
        res_next.dq_dangle_far  = bpfj_pkg::sat48(-t1);
        res_next.dq_dvm_far     = bpfj_pkg::sat48(a2n);
        if (!s5_svc_reg)
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    assign out_valid = v_reg[5];
    assign result    = res_reg;

    `ASSERT_IMPL(a_angle_pair_p, out_valid, result.dp_dangle_far == -result.dp_dangle_near)
    `ASSERT_IMPL(a_angle_pair_q, out_valid, result.dq_dangle_far == -result.dq_dangle_near)

endmodule
